@@ sv/scc_pkg.sv @@
// shared types, constants and tables for the hyperbolic cordic core
package scc_pkg;

	// datapath word and fixed-point format
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 28;
	localparam int SHIFT_BITS = $clog2(WORD_BITS);
	localparam int ITER_BITS = 6;

	// micro-rotations k = 1 .. WORD_BITS-1, with k = 4 and k = 13 done twice
	localparam int NUM_STEPS = WORD_BITS - 1 + 2;

	// inverse hyperbolic gain, rounded to FRAC_BITS fraction bits
	localparam logic [WORD_BITS-1:0] INV_GAIN = 32'd324135026;

	// iteration count after reset
	localparam logic [ITER_BITS-1:0] ITER_RESET = 6'd32;

	typedef logic [WORD_BITS-1:0] word_t;

	// one micro-rotation slot: shift amount and repeat flag
	typedef struct packed {
		logic [SHIFT_BITS-1:0] shift;
		logic                  rep;
	} step_t;

	// rotation state carried down the pipeline
	typedef struct packed {
		word_t x;
		word_t y;
		word_t z;
		logic  neg;
	} rot_t;

	// atanh(2^-k) in the datapath format
	function automatic word_t atanh_const(input logic [SHIFT_BITS-1:0] k);
		word_t a;
		case (k)
			5'd1:    a = 32'd147453245;
			5'd2:    a = 32'd68561855;
			5'd3:    a = 32'd33730852;
			5'd4:    a = 32'd16799113;
			5'd5:    a = 32'd8391340;
			5'd6:    a = 32'd4194645;
			5'd7:    a = 32'd2097195;
			5'd8:    a = 32'd1048581;
			5'd9:    a = 32'd524289;
			5'd10:   a = 32'd262144;
			5'd11:   a = 32'd131072;
			5'd12:   a = 32'd65536;
			5'd13:   a = 32'd32768;
			5'd14:   a = 32'd16384;
			5'd15:   a = 32'd8192;
			5'd16:   a = 32'd4096;
			5'd17:   a = 32'd2048;
			5'd18:   a = 32'd1024;
			5'd19:   a = 32'd512;
			5'd20:   a = 32'd256;
			5'd21:   a = 32'd128;
			5'd22:   a = 32'd64;
			5'd23:   a = 32'd32;
			5'd24:   a = 32'd16;
			5'd25:   a = 32'd8;
			5'd26:   a = 32'd4;
			5'd27:   a = 32'd2;
			5'd28:   a = 32'd1;
			5'd29:   a = 32'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

	// slot index along the pipeline to shift amount and repeat flag
	function automatic step_t step_of(input int idx);
		step_t s;
		if (idx <= 3) begin
			s.shift = SHIFT_BITS'(idx + 1);
			s.rep   = 1'b0;
		end else if (idx == 4) begin
			s.shift = SHIFT_BITS'(4);
			s.rep   = 1'b1;
		end else if (idx <= 13) begin
			s.shift = SHIFT_BITS'(idx);
			s.rep   = 1'b0;
		end else if (idx == 14) begin
			s.shift = SHIFT_BITS'(13);
			s.rep   = 1'b1;
		end else begin
			s.shift = SHIFT_BITS'(idx - 1);
			s.rep   = 1'b0;
		end
		return s;
	endfunction

endpackage

@@ sv/sinh_cosh_cordic_core.sv @@
// hyperbolic cordic core, rotation mode: theta in, sinh and cosh out
// The core takes one angle per clock when the output does not stall and returns
// sinh and cosh through one input register followed by 33 registered
// micro-rotation stages (shifts 1 to 31, with shifts 4 and 13 done twice).
// Angles, sinh and cosh are signed Q3.28 words; the method holds for
// |theta| < 1.118 and words wrap outside it. The iteration register sets how
// many shifts take part (values above 32 act as 32, 0 and 1 give cosh = 1/K,
// sinh = 0); write it only while no request is in flight. Each stage holds when
// its successor is full, so a stalled output never drops or repeats a result.
module sinh_cosh_cordic_core (
	input  logic        clk,
	input  logic        arst_n,
	// iteration count register
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	// angle requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] theta
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] sinh_out, [63:32] cosh_out
);

	localparam int NS = scc_pkg::NUM_STEPS;

	logic [scc_pkg::ITER_BITS-1:0] iter_q;
	logic [scc_pkg::ITER_BITS-1:0] n_iter;
	logic                          in_valid_s0;
	scc_pkg::rot_t                 in_data_s0;
	logic                          valid_st [0:NS];
	logic                          ready_st [0:NS];
	scc_pkg::rot_t                 data_st  [0:NS];

	// iteration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= scc_pkg::ITER_RESET;
		end else if (cfg_we) begin
			iter_q <= cfg_wdata;
		end
	end

	// clamp the count to the word width
	assign n_iter = (iter_q > scc_pkg::ITER_BITS'(scc_pkg::WORD_BITS))
		? scc_pkg::ITER_BITS'(scc_pkg::WORD_BITS) : iter_q;

	// input register loads the start vector
	assign s_tready = !in_valid_s0 || ready_st[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s0 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s0.x   <= scc_pkg::INV_GAIN;
			in_data_s0.y   <= '0;
			in_data_s0.z   <= s_tdata;
			in_data_s0.neg <= 1'b0;
		end
	end

	assign valid_st[0] = in_valid_s0;
	assign data_st[0]  = in_data_s0;

	// micro-rotation stages
	for (genvar i = 0; i < NS; i++) begin : g_step
		scc_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (scc_pkg::step_of(i)),
			.n_iter    (n_iter),
			.in_valid  (valid_st[i]),
			.in_data   (data_st[i]),
			.in_ready  (ready_st[i]),
			.out_valid (valid_st[i+1]),
			.out_data  (data_st[i+1]),
			.out_ready (ready_st[i+1])
		);
	end

	// result side
	assign ready_st[NS] = m_tready;
	assign m_tvalid     = valid_st[NS];
	assign m_tdata      = {data_st[NS].x, data_st[NS].y};

endmodule

@@ sv/scc_stage.sv @@
// one hyperbolic micro-rotation with its pipeline register
module scc_stage (
	input  logic                            clk,
	input  logic                            arst_n,
	input  scc_pkg::step_t                  step,
	input  logic [scc_pkg::ITER_BITS-1:0]   n_iter,
	input  logic                            in_valid,
	input  scc_pkg::rot_t                   in_data,
	output logic                            in_ready,
	output logic                            out_valid,
	output scc_pkg::rot_t                   out_data,
	input  logic                            out_ready
);

	logic           rot_valid_s1;
	scc_pkg::rot_t  rot_data_s1;
	scc_pkg::rot_t  rot_next;
	scc_pkg::word_t dx;
	scc_pkg::word_t dy;
	scc_pkg::word_t ang;
	logic           neg;
	logic           active;

	// stage advances when empty or when the next one takes its request
	assign in_ready = !rot_valid_s1 || out_ready;

	// micro-rotation; a repeated step keeps the earlier direction
	always_comb begin
		neg    = step.rep ? in_data.neg : in_data.z[scc_pkg::WORD_BITS-1];
		active = {1'b0, step.shift} < n_iter;
		dx     = scc_pkg::word_t'($signed(in_data.y) >>> step.shift);
		dy     = scc_pkg::word_t'($signed(in_data.x) >>> step.shift);
		ang    = scc_pkg::atanh_const(step.shift);
		rot_next = in_data;
		if (active) begin
			rot_next.neg = neg;
			if (neg) begin
				rot_next.x = in_data.x - dx;
				rot_next.y = in_data.y - dy;
				rot_next.z = in_data.z + ang;
			end else begin
				rot_next.x = in_data.x + dx;
				rot_next.y = in_data.y + dy;
				rot_next.z = in_data.z - ang;
			end
		end
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			rot_valid_s1 <= in_valid;
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rot_data_s1 <= rot_next;
		end
	end

	assign out_valid = rot_valid_s1;
	assign out_data  = rot_data_s1;

endmodule
